[hw/rtl/hmtp_pkg.sv]
// types, codes and constants shared by the height-map text parser
`default_nettype none

package hmtp_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 1024;
    localparam int FQ_DEPTH        = 2;
    localparam int OQ_DEPTH        = 4;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_EMPTY    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_SHORT    = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_DIGITS,
        PH_JUNK,
        PH_COMMA,
        PH_PREFIX,
        PH_HEX,
        PH_CDONE
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [9:0]         row_index;
        logic [9:0]         col_index;
        logic signed [31:0] depth;
        logic [31:0]        color;
        logic [10:0]        total_rows;
        logic [10:0]        total_cols;
        logic [1:0]         error_code;
    } out_item_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic       eof;
        logic       nl;
        logic       sp;
        logic       comma;
        logic       digit;
        logic       sign;
        logic       minus;
        logic       hex;
        logic [3:0] val;
    } cls_t;

    // up to two records written into the result queue in one cycle
    typedef struct packed {
        logic [1:0]            vld;
        out_item_t [1:0]       rec;
    } rec_push_t;

endpackage

`default_nettype wire

[hw/rtl/hmtp_if.sv]
// valid/ready channel carrying one transaction payload
`default_nettype none

interface hmtp_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/hmtp_front.sv]
// front end: accepts bytes, classifies them and queues them for the back end
`default_nettype none

module hmtp_front
    import hmtp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    hmtp_if.sink      in_stream,
    hmtp_if.source    cls_out
);

    localparam int PW = $clog2(FQ_DEPTH);
    localparam int CNTW = $clog2(FQ_DEPTH + 1);
    localparam logic [CNTW-1:0] FULL = CNTW'(FQ_DEPTH);

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] LA_BIAS  = 8'h57;
    localparam logic [7:0] UA_BIAS  = 8'h37;

    cls_t            mem_reg [FQ_DEPTH];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   wp_next;
    logic [PW-1:0]   rp_reg;
    logic [PW-1:0]   rp_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    cls_t            cls;
    logic            push;
    logic            pop;
    logic [7:0]      b;
    logic [7:0]      hv;

    assign b = in_stream.payload.in_byte;

    always_comb
    begin
        cls       = '0;
        hv        = 8'd0;
        cls.eof   = in_stream.payload.end_of_file;
        cls.nl    = (b == CH_NL);
        cls.sp    = (b == CH_SP);
        cls.comma = (b == CH_COMMA);
        cls.digit = (b >= CH_0) && (b <= CH_9);
        cls.minus = (b == CH_MINUS);
        cls.sign  = (b == CH_PLUS) || (b == CH_MINUS);
        if (cls.digit)
        begin
            cls.hex = 1'b1;
            hv      = b - CH_0;
        end
        else if ((b >= CH_LA) && (b <= CH_LF))
        begin
            cls.hex = 1'b1;
            hv      = b - LA_BIAS;
        end
        else if ((b >= CH_UA) && (b <= CH_UF))
        begin
            cls.hex = 1'b1;
            hv      = b - UA_BIAS;
        end
        cls.val = hv[3:0];
    end

    assign in_stream.ready = (cnt_reg != FULL);
    assign push            = in_stream.valid && in_stream.ready;
    assign cls_out.valid   = (cnt_reg != '0);
    assign cls_out.payload = mem_reg[rp_reg];
    assign pop             = cls_out.valid && cls_out.ready;

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + CNTW'(push) - CNTW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hmtp_back.sv]
// back end: token and line state, emits point, finish and error records
`default_nettype none

module hmtp_back
    import hmtp_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    hmtp_if.sink            cls_in,
    output rec_push_t       push,
    input  wire logic       room
);

    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam logic [RW-1:0] MAX_R = RW'(MAX_ROWS);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_COLUMNS);
    localparam logic [36:0] LIM_POS = 37'h0_7FFF_FFFF;
    localparam logic [36:0] LIM_NEG = 37'h0_8000_0000;

    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] pos_next;
    phase_t        phase_reg;
    phase_t        phase_next;
    logic          neg_reg;
    logic          neg_next;
    logic [32:0]   dacc_reg;
    logic [32:0]   dacc_next;
    logic [31:0]   cacc_reg;
    logic [31:0]   cacc_next;
    logic          first_reg;
    logic          first_next;
    logic          err_reg;
    logic          err_next;
    logic          counting_reg;
    logic          counting_next;
    logic          live_reg;
    logic          live_next;
    logic          line_open_reg;
    logic          line_open_next;
    logic          fin_reg;
    logic          fin_next;

    cls_t          it;
    logic          n;
    logic          end_line;
    logic [31:0]   mag;
    logic [31:0]   dep;
    logic [31:0]   colr;
    logic [36:0]   prod;
    logic          num;

    function automatic logic [10:0] rows11(input logic [RW-1:0] v);
        logic [RW+10:0] w;
        w = {11'd0, v};
        return w[10:0];
    endfunction

    function automatic logic [9:0] rows10(input logic [RW-1:0] v);
        logic [RW+9:0] w;
        w = {10'd0, v};
        return w[9:0];
    endfunction

    function automatic logic [10:0] cols11(input logic [CW-1:0] v);
        logic [CW+10:0] w;
        w = {11'd0, v};
        return w[10:0];
    endfunction

    function automatic logic [9:0] cols10(input logic [CW-1:0] v);
        logic [CW+9:0] w;
        w = {10'd0, v};
        return w[9:0];
    endfunction

    function automatic out_item_t mk_rec(
        input logic [1:0]  kind,
        input logic [9:0]  r,
        input logic [9:0]  c,
        input logic [31:0] d,
        input logic [31:0] cv,
        input logic [10:0] rows,
        input logic [10:0] cols,
        input logic [1:0]  code
    );
        out_item_t o;
        o.result_kind = kind;
        o.row_index   = r;
        o.col_index   = c;
        o.depth       = d;
        o.color       = cv;
        o.total_rows  = rows;
        o.total_cols  = cols;
        o.error_code  = code;
        return o;
    endfunction

    assign cls_in.ready = room;
    assign it           = cls_in.payload;
    assign num          = it.digit || it.sign;
    assign mag          = dacc_reg[31:0];
    assign dep          = neg_reg ? (32'd0 - mag) : mag;
    assign colr         = ((phase_reg == PH_PREFIX) || (phase_reg == PH_HEX)
                           || (phase_reg == PH_CDONE)) ? {cacc_reg[23:0], 8'hFF} : '1;
    assign end_line     = it.eof ? line_open_reg : it.nl;

    always_comb
    begin
        row_next       = row_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        dacc_next      = dacc_reg;
        cacc_next      = cacc_reg;
        first_next     = first_reg;
        err_next       = err_reg;
        counting_next  = counting_reg;
        live_next      = live_reg;
        line_open_next = line_open_reg;
        fin_next       = fin_reg;
        push           = '0;
        n              = 1'b0;
        prod           = '0;

        if (cls_in.valid && room && !err_reg && !fin_reg)
        begin
            // token end on space, newline or end of stream
            if (end_line || (!it.eof && it.sp))
            begin
                if ((phase_reg != PH_IDLE) && live_reg)
                begin
                    push.rec[n] = mk_rec(KIND_POINT, rows10(row_reg),
                                         cols10(pos_reg - 1'b1), dep, colr,
                                         rows11(row_reg), cols11(count_reg), ERR_NONE);
                    push.vld[n] = 1'b1;
                    n           = 1'b1;
                end
                phase_next = PH_IDLE;
                live_next  = 1'b0;
                neg_next   = 1'b0;
                dacc_next  = '0;
                cacc_next  = '0;
            end

            if (end_line)
            begin
                if (row_reg < MAX_R)
                begin
                    if (!first_reg && (pos_reg < count_reg))
                    begin
                        push.rec[n] = mk_rec(KIND_ERROR, '0, '0, '0, '0,
                                             rows11(row_reg), cols11(count_reg), ERR_SHORT);
                        push.vld[n] = 1'b1;
                        n           = 1'b1;
                        err_next    = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                if (!err_next)
                begin
                    first_next     = 1'b0;
                    counting_next  = 1'b0;
                    pos_next       = '0;
                    line_open_next = 1'b0;
                end
            end

            if (it.eof)
            begin
                if (!err_next)
                begin
                    fin_next = 1'b1;
                    if (row_next == '0)
                    begin
                        push.rec[n] = mk_rec(KIND_ERROR, '0, '0, '0, '0,
                                             rows11(row_next), cols11(count_next), ERR_EMPTY);
                        err_next    = 1'b1;
                    end
                    else
                    begin
                        push.rec[n] = mk_rec(KIND_DONE, '0, '0, '0, '0,
                                             rows11(row_next), cols11(count_next), ERR_NONE);
                    end
                    push.vld[n] = 1'b1;
                end
            end
            else if (!it.nl)
            begin
                line_open_next = 1'b1;
                if (!it.sp)
                begin
                    // token start
                    if (phase_reg == PH_IDLE)
                    begin
                        live_next = 1'b0;
                        if (row_reg < MAX_R)
                        begin
                            if (first_reg)
                            begin
                                if (counting_reg && num && (count_reg < MAX_C))
                                begin
                                    count_next = count_reg + 1'b1;
                                    live_next  = 1'b1;
                                end
                                else
                                begin
                                    counting_next = 1'b0;
                                end
                            end
                            else
                            begin
                                live_next = (pos_reg < count_reg);
                            end
                        end
                        if (pos_reg < MAX_C)
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                        phase_next = PH_START;
                    end

                    case (phase_next)
                        PH_START, PH_DIGITS:
                        begin
                            if (it.comma)
                            begin
                                phase_next = PH_COMMA;
                            end
                            else if ((phase_next == PH_START) && it.sign)
                            begin
                                neg_next   = it.minus;
                                phase_next = PH_DIGITS;
                            end
                            else if (it.digit)
                            begin
                                phase_next = PH_DIGITS;
                                if (live_next)
                                begin
                                    prod = {dacc_reg, 3'b000} + {2'b00, dacc_reg, 1'b0}
                                           + {33'd0, it.val};
                                    dacc_next = prod[32:0];
                                    if (prod > (neg_next ? LIM_NEG : LIM_POS))
                                    begin
                                        push.rec[n] = mk_rec(KIND_ERROR, '0, '0, '0, '0,
                                                             rows11(row_next),
                                                             cols11(count_next),
                                                             ERR_OVERFLOW);
                                        push.vld[n] = 1'b1;
                                        err_next    = 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                phase_next = PH_JUNK;
                            end
                        end
                        PH_JUNK:
                        begin
                            if (it.comma)
                            begin
                                phase_next = PH_COMMA;
                            end
                        end
                        PH_COMMA:
                        begin
                            if (!it.comma)
                            begin
                                phase_next = PH_PREFIX;
                            end
                        end
                        PH_PREFIX:
                        begin
                            phase_next = it.comma ? PH_CDONE : PH_HEX;
                        end
                        PH_HEX:
                        begin
                            if (it.hex)
                            begin
                                cacc_next = {cacc_reg[27:0], it.val};
                            end
                            else
                            begin
                                phase_next = PH_CDONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_next;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            phase_reg     <= PH_IDLE;
            neg_reg       <= 1'b0;
            dacc_reg      <= '0;
            cacc_reg      <= '0;
            first_reg     <= 1'b1;
            err_reg       <= 1'b0;
            counting_reg  <= 1'b1;
            live_reg      <= 1'b0;
            line_open_reg <= 1'b0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            dacc_reg      <= dacc_next;
            cacc_reg      <= cacc_next;
            first_reg     <= first_next;
            err_reg       <= err_next;
            counting_reg  <= counting_next;
            live_reg      <= live_next;
            line_open_reg <= line_open_next;
            fin_reg       <= fin_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hmtp_outq.sv]
// result queue: takes up to two records per cycle, delivers one per transaction
`default_nettype none

module hmtp_outq
    import hmtp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire rec_push_t  push,
    output logic            room,
    hmtp_if.source          out_stream
);

    localparam int PW = $clog2(OQ_DEPTH);
    localparam int CNTW = $clog2(OQ_DEPTH + 1);
    localparam logic [CNTW-1:0] ROOM_MAX = CNTW'(OQ_DEPTH - 2);

    out_item_t       mem_reg [OQ_DEPTH];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   wp_next;
    logic [PW-1:0]   rp_reg;
    logic [PW-1:0]   rp_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic            pop;
    logic [1:0]      npush;
    logic [PW-1:0]   wp1;

    assign room               = (cnt_reg <= ROOM_MAX);
    assign out_stream.valid   = (cnt_reg != '0);
    assign out_stream.payload = mem_reg[rp_reg];
    assign pop                = out_stream.valid && out_stream.ready;
    assign npush              = {1'b0, push.vld[0]} + {1'b0, push.vld[1]};
    assign wp1                = wp_reg + 1'b1;

    always_comb
    begin
        wp_next  = wp_reg + PW'(npush);
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + CNTW'(npush) - CNTW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.vld[0])
        begin
            mem_reg[wp_reg] <= push.rec[0];
        end
        if (push.vld[1])
        begin
            mem_reg[wp1] <= push.rec[1];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/height_map_text_parser.sv]
// top level of the height-map text parser
//
//   channel     dir   payload      transaction
//   in_stream   in    in_item_t    one text byte or end of stream
//   out_stream  out   out_item_t   one point, finish or error record
//
// one byte per cycle sustained while the result queue has room
// the back end waits only while the result queue has fewer than two free slots
// a two-entry byte queue still takes input bytes during such a wait until it fills
// reset is asynchronous and needs no clearing pass; the parser is ready for a byte
// as soon as reset is released
`default_nettype none

module height_map_text_parser
    import hmtp_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hmtp_if.sink      in_stream,
    hmtp_if.source    out_stream
);

    rec_push_t push;
    logic      room;

    hmtp_if #(.payload_t(cls_t)) cls_ch ();

    hmtp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream),
        .cls_out   (cls_ch)
    );

    hmtp_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cls_in (cls_ch),
        .push   (push),
        .room   (room)
    );

    hmtp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .out_stream (out_stream)
    );

endmodule

`default_nettype wire

[sim/tb_height_map_text_parser.sv]
// testbench for the height-map text parser: one text stream in, point/finish/error records checked
`timescale 1ns / 100ps

module tb_height_map_text_parser;
    import hmtp_pkg::*;

    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    localparam int NUM_FORMS = 19;
    localparam int RANDOM_TEXT_BYTES = 1400;

    typedef enum {
        END_CLEAN,
        END_OPEN_LINE,
        END_SHORT_LINE,
        END_OVERFLOW
    } stream_end_t;

    logic clk = 1'b0;
    logic rst_n;

    hmtp_if #(.payload_t(in_item_t))  in_ch ();
    hmtp_if #(.payload_t(out_item_t)) out_ch ();

    height_map_text_parser uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_ch),
        .out_stream (out_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // parser state mirror
    logic [10:0] rows_done;
    logic [10:0] cols_fixed;
    logic [10:0] col_pos;
    phase_t      phase;
    logic        neg_depth;
    logic [63:0] depth_mag;
    logic [31:0] hex_acc;
    logic        first_line;
    logic        counting_open;
    logic        token_live;
    logic        line_open;
    logic        stream_done;
    logic        error_seen;

    out_item_t pending_records[$];
    int        mismatch_count = 0;
    int        text_bytes_sent = 0;
    bit        steady_flow = 1'b0;

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int idle_cycles();
        return steady_flow ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            return int'(c - CH_LOWER_A) + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            return int'(c - CH_UPPER_A) + 10;
        return -1;
    endfunction

    task automatic clear_parser_state();
        rows_done     = '0;
        cols_fixed    = '0;
        col_pos       = '0;
        first_line    = 1'b1;
        counting_open = 1'b1;
        line_open     = 1'b0;
        stream_done   = 1'b0;
        error_seen    = 1'b0;
        clear_token_state();
    endtask

    task automatic clear_token_state();
        phase      = PH_IDLE;
        token_live = 1'b0;
        neg_depth  = 1'b0;
        depth_mag  = '0;
        hex_acc    = '0;
    endtask

    task automatic push_record(logic [1:0] kind, logic [9:0] row, logic [9:0] col,
                               logic [31:0] dep, logic [31:0] colr, logic [1:0] code);
        out_item_t r;
        r.result_kind = kind;
        r.row_index   = row;
        r.col_index   = col;
        r.depth       = dep;
        r.color       = colr;
        r.total_rows  = rows_done;
        r.total_cols  = cols_fixed;
        r.error_code  = code;
        pending_records.push_back(r);
    endtask

    task automatic raise_parse_error(logic [1:0] code);
        error_seen = 1'b1;
        push_record(KIND_ERROR, '0, '0, '0, '0, code);
    endtask

    task automatic close_token();
        logic [31:0] mag;
        logic [31:0] dep;
        logic [31:0] colr;
        logic [10:0] col_prev;
        if (phase != PH_IDLE && token_live)
        begin
            mag      = depth_mag[31:0];
            dep      = neg_depth ? (32'd0 - mag) : mag;
            colr     = (phase >= PH_PREFIX) ? {hex_acc[23:0], 8'hFF} : 32'hFFFF_FFFF;
            col_prev = col_pos - 11'd1;
            push_record(KIND_POINT, rows_done[9:0], col_prev[9:0], dep, colr, ERR_NONE);
        end
        clear_token_state();
    endtask

    task automatic open_token(logic [7:0] c);
        logic numeric;
        numeric    = (c >= CH_0 && c <= CH_9) || c == CH_PLUS || c == CH_MINUS;
        token_live = 1'b0;
        if (rows_done < MAX_ROWS_DEF)
        begin
            if (first_line)
            begin
                if (counting_open && numeric && cols_fixed < MAX_COLUMNS_DEF)
                begin
                    cols_fixed = cols_fixed + 11'd1;
                    token_live = 1'b1;
                end
                else
                begin
                    counting_open = 1'b0;
                end
            end
            else
            begin
                token_live = (col_pos < cols_fixed);
            end
        end
        if (col_pos < MAX_COLUMNS_DEF)
            col_pos = col_pos + 11'd1;
        phase = PH_START;
    endtask

    task automatic close_line();
        close_token();
        if (rows_done < MAX_ROWS_DEF)
        begin
            if (!first_line && col_pos < cols_fixed)
            begin
                raise_parse_error(ERR_SHORT);
                return;
            end
            rows_done = rows_done + 11'd1;
        end
        first_line    = 1'b0;
        counting_open = 1'b0;
        col_pos       = '0;
        line_open     = 1'b0;
    endtask

    task automatic advance_token(logic [7:0] c);
        int          nib;
        logic        is_digit;
        logic [63:0] limit;
        is_digit = (c >= CH_0 && c <= CH_9);
        case (phase)
            PH_START, PH_DIGITS:
            begin
                if (c == CH_COMMA)
                begin
                    phase = PH_COMMA;
                end
                else if (phase == PH_START && (c == CH_PLUS || c == CH_MINUS))
                begin
                    neg_depth = (c == CH_MINUS);
                    phase     = PH_DIGITS;
                end
                else if (is_digit)
                begin
                    phase = PH_DIGITS;
                    if (token_live)
                    begin
                        limit     = neg_depth ? 64'd2147483648 : 64'd2147483647;
                        depth_mag = depth_mag * 64'd10 + 64'(c - CH_0);
                        if (depth_mag > limit)
                            raise_parse_error(ERR_OVERFLOW);
                    end
                end
                else
                begin
                    phase = PH_JUNK;
                end
            end
            PH_JUNK:
            begin
                if (c == CH_COMMA)
                    phase = PH_COMMA;
            end
            PH_COMMA:
            begin
                if (c != CH_COMMA)
                    phase = PH_PREFIX;
            end
            PH_PREFIX:
            begin
                phase = (c == CH_COMMA) ? PH_CDONE : PH_HEX;
            end
            PH_HEX:
            begin
                nib = hex_nibble(c);
                if (nib < 0)
                    phase = PH_CDONE;
                else
                    hex_acc = {hex_acc[27:0], nib[3:0]};
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic parse_item(in_item_t it);
        if (error_seen || stream_done)
            return;
        if (it.end_of_file)
        begin
            if (line_open)
            begin
                close_line();
                if (error_seen)
                    return;
            end
            stream_done = 1'b1;
            if (rows_done == 0)
                raise_parse_error(ERR_EMPTY);
            else
                push_record(KIND_DONE, '0, '0, '0, '0, ERR_NONE);
        end
        else if (it.in_byte == CH_NL)
        begin
            close_line();
        end
        else
        begin
            line_open = 1'b1;
            if (it.in_byte == CH_SP)
            begin
                close_token();
            end
            else
            begin
                if (phase == PH_IDLE)
                    open_token(it.in_byte);
                advance_token(it.in_byte);
            end
        end
    endtask

    task automatic send_item(in_item_t it);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        parse_item(it);
        text_bytes_sent++;
    endtask

    task automatic send_char(logic [7:0] b);
        in_item_t it;
        it.in_byte     = b;
        it.end_of_file = 1'b0;
        send_item(it);
    endtask

    task automatic send_end_of_file();
        in_item_t it;
        it.in_byte     = 8'($urandom_range(0, 255));
        it.end_of_file = 1'b1;
        send_item(it);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_spaces(int lo, int hi);
        repeat ($urandom_range(lo, hi)) send_char(CH_SP);
    endtask

    function automatic string hex_digits(int n);
        string s;
        string digit_set;
        s         = "";
        digit_set = "0123456789abcdefABCDEF";
        repeat (n) s = $sformatf("%s%c", s, digit_set[$urandom_range(0, 21)]);
        return s;
    endfunction

    // always starts with a digit or a sign
    task automatic send_depth_token();
        int    v;
        string s;
        if ($urandom_range(0, 4) == 0)
            v = $urandom;
        else
            v = int'($urandom_range(0, 4000)) - 2000;
        s = $sformatf("%0d", v);
        if (v >= 0 && $urandom_range(0, 3) == 0)
            s = {"+", s};
        if ($urandom_range(0, 1))
        begin
            s = {s, ","};
            if ($urandom_range(0, 7) == 0)
                s = {s, ","};
            case ($urandom_range(0, 5))
                0: s = {s, "0X"};
                1: s = $sformatf("%s%c%c", s, $urandom_range(8'h2D, 8'h7E),
                                 $urandom_range(8'h2D, 8'h7E));
                default: s = {s, "0x"};
            endcase
            s = {s, hex_digits($urandom_range(0, 10))};
        end
        if ($urandom_range(0, 9) == 0)
            s = {s, "q;"};
        send_text(s);
    endtask

    // one token of arbitrary bytes, never a separator
    task automatic send_noise_token();
        logic [7:0] b;
        repeat ($urandom_range(1, 6))
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_NL || b == CH_SP)
                b = b ^ 8'h80;
            send_char(b);
        end
    endtask

    task automatic send_row(int n_tokens, bit noisy);
        if ($urandom_range(0, 3) == 0)
            send_spaces(1, 2);
        for (int i = 0; i < n_tokens; i++)
        begin
            if (i > 0)
                send_spaces(1, 3);
            if (noisy && $urandom_range(0, 5) == 0)
                send_noise_token();
            else if (i >= cols_fixed && $urandom_range(0, 2) == 0)
                send_text("98765432109876,0x7");
            else
                send_depth_token();
        end
        if ($urandom_range(0, 3) == 0)
            send_spaces(1, 2);
    endtask

    function automatic string token_form(int k);
        case (k)
            0:  return "0";
            1:  return "-0";
            2:  return "+";
            3:  return "-";
            4:  return "abc";
            5:  return "12abc34";
            6:  return "5,0x";
            7:  return "5,";
            8:  return "5,,,";
            9:  return "5,0,x";
            10: return "7,0xdeadBEEF12";
            11: return "3,0X1g2";
            12: return "9,zz10";
            13: return "1,0xFF,0x3";
            14: return "-12,,0xab";
            15: return "2147483647";
            16: return "-2147483648,0x";
            17: return "\377\200";
            default: return "+7,0xFFFFFFFF";
        endcase
    endfunction

    task automatic test_header_line();
        steady_flow = 1'($urandom_range(0, 1));
        send_spaces(0, 2);
        send_text("-2147483648,0xFFffFFff");
        send_spaces(1, 3);
        send_text("+2147483647,0x0");
        repeat ($urandom_range(0, 3))
        begin
            send_spaces(1, 2);
            send_depth_token();
        end
        // a non-numeric token closes the column count
        if ($urandom_range(0, 1))
            send_text(" x 99999999999 -5,0x1");
        send_spaces(0, 1);
        send_char(CH_NL);
    endtask

    task automatic test_token_forms();
        int k;
        k           = 0;
        steady_flow = 1'b0;
        while (k < NUM_FORMS)
        begin
            for (int i = 0; i < cols_fixed; i++)
            begin
                if (i > 0)
                    send_spaces(1, 2);
                if (k < NUM_FORMS)
                begin
                    send_text(token_form(k));
                    k++;
                end
                else
                begin
                    send_depth_token();
                end
            end
            if ($urandom_range(0, 1))
                send_text(" 99999999999,0xab");
            send_char(CH_NL);
        end
    endtask

    task automatic test_random_rows();
        int start_count;
        start_count = text_bytes_sent;
        while (text_bytes_sent - start_count < RANDOM_TEXT_BYTES)
        begin
            steady_flow = ($urandom_range(0, 4) == 0);
            send_row(cols_fixed + $urandom_range(0, 2), $urandom_range(0, 9) < 3);
            if ($urandom_range(0, 9) == 0)
                send_char(CH_CR);
            send_char(CH_NL);
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_stream_end();
        stream_end_t ending;
        int          bad_col;
        in_item_t    it;
        ending = stream_end_t'($urandom_range(0, 3));
        case (ending)
            END_CLEAN:
            begin
                send_end_of_file();
            end
            END_OPEN_LINE:
            begin
                send_row(cols_fixed + $urandom_range(0, 1), 1'b0);
                send_end_of_file();
            end
            END_SHORT_LINE:
            begin
                send_row($urandom_range(0, cols_fixed - 1), 1'b0);
                if ($urandom_range(0, 1))
                    send_char(CH_NL);
                send_end_of_file();
            end
            default:
            begin
                bad_col = $urandom_range(0, cols_fixed - 1);
                for (int i = 0; i < cols_fixed; i++)
                begin
                    if (i > 0)
                        send_spaces(1, 2);
                    if (i == bad_col)
                    begin
                        if ($urandom_range(0, 1))
                            send_text("2147483648");
                        else
                            send_text("-2147483649");
                    end
                    else
                        send_depth_token();
                end
                send_char(CH_NL);
                send_end_of_file();
            end
        endcase
        // everything after the terminal record is dropped
        repeat (12)
        begin
            it.in_byte     = 8'($urandom_range(0, 255));
            it.end_of_file = 1'($urandom_range(0, 1));
            send_item(it);
        end
    endtask

    task automatic check_record(out_item_t got);
        out_item_t want;
        if (pending_records.size() == 0)
        begin
            report_mismatch($sformatf("record with no expectation, kind %0d", got.result_kind));
            return;
        end
        want = pending_records.pop_front();
        if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind got %0d expected %0d",
                                      got.result_kind, want.result_kind));
        if (got.row_index !== want.row_index)
            report_mismatch($sformatf("row_index got %0d expected %0d",
                                      got.row_index, want.row_index));
        if (got.col_index !== want.col_index)
            report_mismatch($sformatf("col_index got %0d expected %0d",
                                      got.col_index, want.col_index));
        if (got.depth !== want.depth)
            report_mismatch($sformatf("depth got %0d expected %0d", got.depth, want.depth));
        if (got.color !== want.color)
            report_mismatch($sformatf("color got %h expected %h", got.color, want.color));
        if (got.total_rows !== want.total_rows)
            report_mismatch($sformatf("total_rows got %0d expected %0d",
                                      got.total_rows, want.total_rows));
        if (got.total_cols !== want.total_cols)
            report_mismatch($sformatf("total_cols got %0d expected %0d",
                                      got.total_cols, want.total_cols));
        if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code got %0d expected %0d",
                                      got.error_code, want.error_code));
    endtask

    // result side: check each transaction, then stall a drawn number of cycles
    initial
    begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                check_record(out_ch.payload);
                stall = idle_cycles();
            end
            else if (stall > 0)
            begin
                stall--;
            end
            out_ch.ready <= (stall == 0);
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        clear_parser_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_header_line();
        test_token_forms();
        test_random_rows();
        test_stream_end();
        in_ch.valid <= 1'b0;

        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("[height_map_text_parser] OK");
        else
            $display("[height_map_text_parser] ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[height_map_text_parser] ERROR");
        $finish;
    end

endmodule
